FILE: rtl/ccaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccaf_pkg: shared types and constants of the core claim affinity filter
// Widths, policy mode and register index codes, and the word that travels
// down the row of core cells.
// ----------------------------------------------------------------------------
package ccaf_pkg;

    localparam int MASK_W    = 16;   // logical cpu slots in a mask
    localparam int CORE_W    = 4;    // physical core index width
    localparam int NUM_CORES = 16;   // one cell per physical core
    localparam int TOKEN_W   = 64;
    localparam int MAP_W     = MASK_W * CORE_W;
    localparam int COUNT_W   = 5;
    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 2;

    // policy_mode codes; the unused code behaves as off
    localparam logic [MODE_W-1:0] MODE_SPREAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] REG_POLICY_MODE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_CPU_COUNT   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_CORE_MAP    = 2'd2;

    // request word as it moves from cell to cell
    typedef struct packed {
        logic                vld;
        logic [MODE_W-1:0]   mode;
        logic [MASK_W-1:0]   want;     // request, trimmed to present cpus
        logic [TOKEN_W-1:0]  token;
        logic                pin;      // exactly one cpu requested
        logic [CORE_W-1:0]   pin_core; // core of the pinned cpu
        logic [MASK_W-1:0]   kept;     // wanted cpus not on foreign cores
        logic [MASK_W-1:0]   free;     // cpus on unclaimed cores
        logic [MASK_W-1:0]   sib;      // cpus on the pinned core
        logic                pin_ok;   // pinned core free or owned by token
    } word_t;

endpackage

FILE: rtl/core_claim_affinity_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_claim_affinity_filter: affinity request filter with per-core claims
// Rewrites a cpu mask by policy mode, keeping a claim and owner per core.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (want_mask, token) enter on in_valid/in_ready; one result
//   word (give_mask, pass_through) leaves on out_valid/out_ready per request.
//   Registers are written through cfg_wen/cfg_index/cfg_data while idle.
//   A request is registered at the head, then walks a row of 16 core cells,
//   one cell per cycle while the row is not held, and lands in the output
//   register. One request is in flight at a time, so a new word is taken
//   only once the previous one has left the row.
//   The next request can be accepted while a finished result still sits in
//   the output register. If the receiver stalls and a second result reaches
//   the end of the row, the whole row holds until the output register frees.
//   Reset clears all core claims at once and sets policy_mode 0, cpu_count
//   16 and core_map 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module core_claim_affinity_filter
    import ccaf_pkg::*;
#(
    parameter int NUM_CPUS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MASK_W-1:0]  want_mask,
    input  logic [TOKEN_W-1:0] token,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MASK_W-1:0]  give_mask,
    output logic               pass_through,
    input  logic               cfg_wen,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [MAP_W-1:0]   cfg_data
);

    localparam int CAP = (NUM_CPUS < MASK_W) ? NUM_CPUS : MASK_W;
    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAP);

    logic [MODE_W-1:0]  policy_mode_reg;
    logic [COUNT_W-1:0] cpu_count_reg;
    logic [MAP_W-1:0]   core_map_reg;

    logic [COUNT_W-1:0] eff_count;
    logic [MASK_W-1:0]  all_mask;
    logic [MASK_W-1:0]  want_m;
    logic [CORE_W-1:0]  pin_idx;
    logic               is_pin;
    word_t              head_word;
    word_t              entry_reg;
    word_t              chain [0:NUM_CORES];

    logic               accept;
    logic               adv;
    logic               tail_load;
    logic               inflight_reg;
    logic               inflight_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [MASK_W-1:0]  give_reg;
    logic               pass_reg;
    logic [MASK_W-1:0]  res_give;
    logic               res_pass;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg <= MODE_SPREAD;
            cpu_count_reg   <= COUNT_W'(16);
            core_map_reg    <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_POLICY_MODE: policy_mode_reg <= cfg_data[MODE_W-1:0];
                REG_CPU_COUNT:   cpu_count_reg   <= cfg_data[COUNT_W-1:0];
                REG_CORE_MAP:    core_map_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // present cpus; out-of-range counts fall back to the supported number
    assign eff_count = ((cpu_count_reg == '0) || (cpu_count_reg > CAP_CNT))
                       ? CAP_CNT : cpu_count_reg;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            all_mask[i] = (COUNT_W'(i) < eff_count);
        end
    end

    // head: trim the mask and find the pinned cpu
    assign want_m = want_mask & all_mask;
    assign is_pin = (want_m != '0) && ((want_m & (want_m - MASK_W'(1))) == '0);

    always_comb
    begin
        pin_idx = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (want_m[i])
            begin
                pin_idx = pin_idx | CORE_W'(i);
            end
        end
    end

    always_comb
    begin
        head_word          = '0;
        head_word.vld      = 1'b1;
        head_word.mode     = policy_mode_reg;
        head_word.want     = want_m;
        head_word.token    = token;
        head_word.pin      = is_pin;
        head_word.pin_core = core_map_reg[{pin_idx, 2'b00} +: CORE_W];
    end

    // handshake and row advance
    assign in_ready  = !inflight_reg;
    assign accept    = in_valid && in_ready;
    assign adv       = !(chain[NUM_CORES].vld && out_valid_reg && !out_ready);
    assign tail_load = adv && chain[NUM_CORES].vld;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept)
        begin
            inflight_next = 1'b1;
        end
        else if (tail_load)
        begin
            inflight_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg    <= '0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (accept)
            begin
                entry_reg <= head_word;
            end
            else if (adv)
            begin
                entry_reg.vld <= 1'b0;
            end
        end
    end

    // row of core cells
    assign chain[0] = entry_reg;

    for (genvar g = 0; g < NUM_CORES; g++)
    begin : g_cell
        ccaf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .core_id  (CORE_W'(g)),
            .all_mask (all_mask),
            .core_map (core_map_reg),
            .word_in  (chain[g]),
            .word_out (chain[g+1])
        );
    end

    ccaf_resolve u_resolve (
        .word_in  (chain[NUM_CORES]),
        .all_mask (all_mask),
        .give     (res_give),
        .pass     (res_pass)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tail_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_load)
        begin
            give_reg <= res_give;
            pass_reg <= res_pass;
        end
    end

    assign out_valid    = out_valid_reg;
    assign give_mask    = give_reg;
    assign pass_through = pass_reg;

endmodule

FILE: rtl/ccaf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccaf_cell: one physical core of the claim chain
// Holds the claimed flag and owner token of its core, folds its cpus into the
// passing word, and in spread mode claims its free core for a single-cpu pin.
// ----------------------------------------------------------------------------
module ccaf_cell
    import ccaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [CORE_W-1:0] core_id,
    input  logic [MASK_W-1:0] all_mask,
    input  logic [MAP_W-1:0]  core_map,
    input  word_t             word_in,
    output word_t             word_out
);

    logic               claimed_reg;
    logic               claimed_next;
    logic [TOKEN_W-1:0] owner_reg;
    word_t              word_reg;
    word_t              word_next;
    logic [MASK_W-1:0]  mine;
    logic               foreign;
    logic               hit;
    logic               take;

    // cpus mapped onto this core
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            mine[i] = all_mask[i] && (core_map[i*CORE_W +: CORE_W] == core_id);
        end
    end

    // claim checks against the passing word
    assign foreign = claimed_reg && (owner_reg != word_in.token);
    assign hit     = word_in.pin && (word_in.pin_core == core_id);
    assign take    = adv && word_in.vld && hit && (word_in.mode == MODE_SPREAD)
                     && !claimed_reg;

    // fold this core into the word
    always_comb
    begin
        word_next      = word_in;
        word_next.kept = word_in.kept | (word_in.want & mine & {MASK_W{!foreign}});
        word_next.free = word_in.free | (mine & {MASK_W{!claimed_reg}});
        if (hit)
        begin
            word_next.sib    = mine;
            word_next.pin_ok = !foreign;
        end
    end

    assign claimed_next = claimed_reg | take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg <= 1'b0;
            word_reg    <= '0;
        end
        else if (adv)
        begin
            claimed_reg <= claimed_next;
            word_reg    <= word_next;
        end
    end

    // owner token, only read once the core is claimed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            owner_reg <= word_in.token;
        end
    end

    assign word_out = word_reg;

endmodule

FILE: rtl/ccaf_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccaf_resolve: result selection at the end of the chain
// Picks the rewritten mask from the accumulated word by policy mode and
// flags pass-through when nothing is to be rewritten.
// ----------------------------------------------------------------------------
module ccaf_resolve
    import ccaf_pkg::*;
(
    input  word_t             word_in,
    input  logic [MASK_W-1:0] all_mask,
    output logic [MASK_W-1:0] give,
    output logic              pass
);

    logic [MASK_W-1:0] spread_give;

    // spread: pin gets its core or the free cores, wide mask loses foreign cpus if any stay
    always_comb
    begin
        if (word_in.want == '0)
        begin
            spread_give = '0;
        end
        else if (word_in.pin)
        begin
            spread_give = word_in.pin_ok ? word_in.sib : word_in.free;
        end
        else if ((word_in.kept == '0) || (word_in.kept == word_in.want))
        begin
            spread_give = '0;
        end
        else
        begin
            spread_give = word_in.kept;
        end
    end

    // mode select
    always_comb
    begin
        unique case (word_in.mode)
            MODE_SPREAD: give = spread_give;
            MODE_FREE:   give = (word_in.want != all_mask) ? all_mask : '0;
            default:     give = '0;
        endcase
    end

    assign pass = (give == '0);

endmodule

FILE: bench/core_claim_affinity_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_claim_affinity_filter_tb: self-checking bench for the affinity filter
// Drives request words with random gaps and checks every result word against
// a behavioural copy of the per-core claim logic. A directed opening covers
// pins, foreign pins, wide masks and every policy mode. Random phases then
// sweep cpu counts and core maps. Registers change only once the filter is idle.
// ----------------------------------------------------------------------------
module core_claim_affinity_filter_tb;
    import ccaf_pkg::*;

    // codes the package leaves unnamed
    localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
    localparam logic [INDEX_W-1:0] REG_UNUSED  = 2'd3;

    localparam int STALL_LIMIT     = 2000;  // cycles with no traffic at all
    localparam int TAIL_CYCLES     = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 100;

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [TOKEN_W-1:0] tok;
    } request_t;

    typedef struct packed {
        logic [MASK_W-1:0] give;
        logic              pass;
    } answer_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [MASK_W-1:0]  want_mask    = '0;
    logic [TOKEN_W-1:0] token        = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [MASK_W-1:0]  give_mask;
    logic               pass_through;
    logic               cfg_wen      = 1'b0;
    logic [INDEX_W-1:0] cfg_index    = '0;
    logic [MAP_W-1:0]   cfg_data     = '0;

    // shadow of the filter's registers and claim table
    logic [MODE_W-1:0]    shadow_mode  = MODE_SPREAD;
    logic [COUNT_W-1:0]   shadow_count = 5'd16;
    logic [MAP_W-1:0]     shadow_map   = '0;
    logic [NUM_CORES-1:0] claimed      = '0;
    logic [TOKEN_W-1:0]   owner [NUM_CORES];

    request_t           request_q [$];
    answer_t            answer_q  [$];
    logic [TOKEN_W-1:0] token_pool [4];

    int   n_err       = 0;
    int   gap_left    = 0;
    int   ready_hold  = 0;
    int   idle_cycles = 0;
    bit   no_gaps     = 1'b0;
    logic in_acc      = 1'b0;

    core_claim_affinity_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .want_mask    (want_mask),
        .token        (token),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .give_mask    (give_mask),
        .pass_through (pass_through),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // cpu count as the filter takes it: 0 or too many means all slots
    function automatic int unsigned present_cpus();
        if (shadow_count == 0 || shadow_count > MASK_W)
            return MASK_W;
        return shadow_count;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // rewrite one request and update the claim table as the filter would
    function automatic answer_t rewrite_request(logic [MASK_W-1:0] mask,
                                                logic [TOKEN_W-1:0] tok);
        int unsigned       n_cpu;
        int unsigned       n_want;
        int                i;
        logic [MASK_W-1:0] present;
        logic [MASK_W-1:0] want;
        logic [MASK_W-1:0] give;
        logic [MASK_W-1:0] kept;
        logic [MASK_W-1:0] sib;
        logic [MASK_W-1:0] unclaimed;
        logic [CORE_W-1:0] pin_core;
        logic [CORE_W-1:0] core;
        answer_t           ans;

        n_cpu     = present_cpus();
        present   = MASK_W'((17'd1 << n_cpu) - 17'd1);
        want      = mask & present;
        n_want    = $countones(want);
        give      = '0;
        kept      = '0;
        sib       = '0;
        unclaimed = '0;
        pin_core  = '0;

        // core of the pinned cpu, only used when one bit is set
        for (i = 0; i < n_cpu; i++)
            if (want[i])
                pin_core = shadow_map[i*CORE_W +: CORE_W];

        // siblings, cpus on free cores, wanted cpus not on foreign cores
        for (i = 0; i < n_cpu; i++)
        begin
            core = shadow_map[i*CORE_W +: CORE_W];
            if (core == pin_core)
                sib[i] = 1'b1;
            if (!claimed[core])
                unclaimed[i] = 1'b1;
            if (want[i] && !(claimed[core] && owner[core] != tok))
                kept[i] = 1'b1;
        end

        case (shadow_mode)
            MODE_FREE:
            begin
                if (n_want < n_cpu)
                    give = present;
            end
            MODE_SPREAD:
            begin
                if (n_want == 1)
                begin
                    if (!claimed[pin_core])
                    begin
                        claimed[pin_core] = 1'b1;
                        owner[pin_core]   = tok;
                        give              = sib;
                    end
                    else if (owner[pin_core] == tok)
                        give = sib;
                    else
                        give = unclaimed;
                end
                else if (n_want > 1)
                begin
                    if (kept != '0 && $countones(kept) != n_want)
                        give = kept;
                end
            end
            default:
                give = '0;
        endcase

        ans.give = give;
        ans.pass = (give == '0);
        return ans;
    endfunction

    task automatic queue_word(logic [MASK_W-1:0] mask, logic [TOKEN_W-1:0] tok);
        request_q.insert(request_q.size(), request_t'({mask, tok}));
    endtask

    // random request: pins, wide masks, extremes and raw noise
    task automatic queue_random();
        int unsigned        n_cpu;
        int unsigned        r;
        logic [MASK_W-1:0]  mask;
        logic [TOKEN_W-1:0] tok;
        n_cpu = present_cpus();
        r     = $urandom_range(0, 99);
        if (r < 40)
            mask = MASK_W'(1) << $urandom_range(0, n_cpu - 1);
        else if (r < 70)
            mask = (MASK_W'(1) << $urandom_range(0, n_cpu - 1))
                 | (MASK_W'(1) << $urandom_range(0, n_cpu - 1))
                 | (MASK_W'($urandom) & MASK_W'($urandom));
        else if (r < 80)
            mask = $urandom_range(0, 1) ? '1 : '0;
        else
            mask = MASK_W'($urandom);
        if ($urandom_range(0, 4) != 0)
            tok = token_pool[$urandom_range(0, 3)];
        else
            tok = {$urandom, $urandom};
        queue_word(mask, tok);
    endtask

    // single register write, shadow follows
    task automatic write_reg(logic [INDEX_W-1:0] index, logic [MAP_W-1:0] data);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            REG_POLICY_MODE: shadow_mode  = data[MODE_W-1:0];
            REG_CPU_COUNT:   shadow_count = data[COUNT_W-1:0];
            REG_CORE_MAP:    shadow_map   = data;
            default:         ;
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_config(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count,
                              logic [MAP_W-1:0] map);
        write_reg(REG_POLICY_MODE, MAP_W'(mode));
        write_reg(REG_CPU_COUNT, MAP_W'(count));
        write_reg(REG_CORE_MAP, map);
    endtask

    // filter idle: nothing queued, nothing offered, no answer awaited
    task automatic wait_idle();
        @(posedge clk);
        while (request_q.size() != 0 || in_valid || answer_q.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n && (!in_valid || in_acc))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_q.size() > 0)
            begin
                rq = request_q.pop_front();
                in_valid  <= 1'b1;
                want_mask <= rq.mask;
                token     <= rq.tok;
                gap_left  <= no_gaps ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_hold > 0)
            begin
                out_ready  <= 1'b0;
                ready_hold <= ready_hold - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!no_gaps)
                    ready_hold <= pick_gap();
            end
        end
    end

    // monitor: check result words, then predict newly accepted requests
    always @(posedge clk)
    begin
        answer_t exp_ans;
        in_acc <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("unexpected result word: give_mask %h pass_through %b",
                           give_mask, pass_through);
                    n_err++;
                end
                else
                begin
                    exp_ans = answer_q.pop_front();
                    if (give_mask !== exp_ans.give)
                    begin
                        $error("give_mask: expected %h, actual %h", exp_ans.give, give_mask);
                        n_err++;
                    end
                    if (pass_through !== exp_ans.pass)
                    begin
                        $error("pass_through: expected %b, actual %b",
                               exp_ans.pass, pass_through);
                        n_err++;
                    end
                end
            end
            if (in_valid && in_ready)
                answer_q.insert(answer_q.size(), rewrite_request(want_mask, token));
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("core_claim_affinity_filter_tb: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        int unsigned phase;
        int unsigned k;

        token_pool[0] = '0;
        token_pool[1] = '1;
        token_pool[2] = {$urandom, $urandom};
        token_pool[3] = {$urandom, $urandom};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // cpu pairs share a core: cpu 2k and 2k+1 on core k
        set_config(MODE_SPREAD, 5'd16, 64'h7766_5544_3322_1100);
        queue_word(16'h0000, token_pool[0]);    // empty request
        queue_word(16'h0001, token_pool[0]);    // claims core 0
        queue_word(16'h0002, token_pool[0]);    // owner pins the sibling
        queue_word(16'h0002, token_pool[1]);    // foreign pin, moved to free cores
        queue_word(16'hFFFF, token_pool[1]);    // wide, loses core 0
        queue_word(16'h000F, token_pool[0]);    // wide, everything kept
        queue_word(16'h0003, token_pool[1]);    // wide, nothing kept
        queue_word(16'h8000, token_pool[1]);    // claims core 7
        for (k = 1; k < 7; k++)
            queue_word(MASK_W'(1) << (2 * k), token_pool[2]);
        queue_word(16'h0004, token_pool[1]);    // foreign pin, no free core left
        queue_word(16'hFFFF, token_pool[2]);
        wait_idle();

        // free mode: full mask, narrow mask, empty mask
        write_reg(REG_POLICY_MODE, MAP_W'(MODE_FREE));
        queue_word(16'hFFFF, token_pool[3]);
        queue_word(16'h0001, token_pool[3]);
        queue_word(16'h0000, token_pool[3]);
        wait_idle();

        write_reg(REG_POLICY_MODE, MAP_W'(MODE_OFF));
        queue_word(16'h0001, token_pool[3]);
        wait_idle();

        write_reg(REG_POLICY_MODE, MAP_W'(MODE_UNUSED));
        queue_word(16'h0001, token_pool[3]);
        wait_idle();

        // unknown index must leave everything as it is
        write_reg(REG_UNUSED, {$urandom, $urandom});
        write_reg(REG_POLICY_MODE, MAP_W'(MODE_SPREAD));
        write_reg(REG_CPU_COUNT, MAP_W'(5'd0));
        queue_word(16'h8000, token_pool[1]);
        wait_idle();

        write_reg(REG_CPU_COUNT, MAP_W'(5'd20));
        queue_word(16'h8000, token_pool[1]);
        wait_idle();

        // one cpu present: high bits dropped
        write_reg(REG_CPU_COUNT, MAP_W'(5'd1));
        write_reg(REG_POLICY_MODE, MAP_W'(MODE_FREE));
        queue_word(16'hFFFE, token_pool[0]);
        queue_word(16'h0001, token_pool[0]);
        wait_idle();

        // random phases, each ending with the sender held until all answers are in
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_config(MODE_SPREAD, 5'd16, {$urandom, $urandom});
                1: set_config(MODE_FREE, 5'($urandom_range(1, 16)), {$urandom, $urandom});
                2: set_config(MODE_SPREAD, 5'($urandom_range(2, 16)), {$urandom, $urandom});
                3: set_config($urandom_range(0, 1) ? MODE_OFF : MODE_UNUSED,
                              5'($urandom), {$urandom, $urandom});
                4: set_config(MODE_SPREAD, 5'd16, '0);
                5: set_config(MODE_SPREAD, 5'd31, '1);
                6: set_config(MODE_FREE, 5'd1, {$urandom, $urandom});
                default: set_config(MODE_SPREAD, 5'($urandom), {$urandom, $urandom});
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (k = 0; k < WORDS_PER_PHASE; k++)
                queue_random();
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (answer_q.size() != 0)
        begin
            $error("%0d result words never arrived", answer_q.size());
            n_err++;
        end
        if (n_err == 0)
            $display("core_claim_affinity_filter_tb: PASS");
        else
            $display("core_claim_affinity_filter_tb: FAIL");
        $finish;
    end

endmodule

FILE: core_claim_affinity_filter.f
rtl/ccaf_pkg.sv
rtl/ccaf_cell.sv
rtl/ccaf_resolve.sv
rtl/core_claim_affinity_filter.sv
bench/core_claim_affinity_filter_tb.sv
